### rtl/scs_pkg.sv
`default_nettype none
package scs_pkg;
  localparam logic [3:0] M_IDLE  = 4'd0;
  localparam logic [3:0] M_IDENT = 4'd1;
  localparam logic [3:0] M_NUM   = 4'd2;
  localparam logic [3:0] M_STR   = 4'd3;
  localparam logic [3:0] M_CHR1  = 4'd4;
  localparam logic [3:0] M_CHR2  = 4'd5;
  localparam logic [3:0] M_OP    = 4'd6;
  localparam logic [3:0] M_SKIP  = 4'd7;

  localparam logic [5:0] K_IDENT  = 6'd0;
  localparam logic [5:0] K_NUM    = 6'd1;
  localparam logic [5:0] K_ZERO   = 6'd2;
  localparam logic [5:0] K_CHAR   = 6'd3;
  localparam logic [5:0] K_STRING = 6'd4;
  localparam logic [5:0] K_KW0    = 6'd5;
  localparam logic [5:0] K_LT     = 6'd22;
  localparam logic [5:0] K_LE     = 6'd23;
  localparam logic [5:0] K_GT     = 6'd24;
  localparam logic [5:0] K_GE     = 6'd25;
  localparam logic [5:0] K_EQ     = 6'd26;
  localparam logic [5:0] K_NE     = 6'd27;
  localparam logic [5:0] K_ASSIGN = 6'd28;
  localparam logic [5:0] K_ERR_CH = 6'd37;
  localparam logic [5:0] K_ERR_SY = 6'd38;
  localparam logic [5:0] K_ERR_ST = 6'd39;
  localparam logic [5:0] K_NONE   = 6'd0;

  localparam logic [19:0] LINE_MAX = 20'hFFFFF;
  localparam logic [15:0] COL_MAX  = 16'hFFFF;

  // each keyword is a six-byte word, left-justified and space-padded, lengths apart
  localparam int NKW = 13;

  function automatic logic [7:0] kw_byte(input logic [3:0] k, input logic [2:0] i);
    logic [47:0] w;
    unique case (k)
      4'd0:  w = "const ";
      4'd1:  w = "int   ";
      4'd2:  w = "char  ";
      4'd3:  w = "void  ";
      4'd4:  w = "main  ";
      4'd5:  w = "if    ";
      4'd6:  w = "do    ";
      4'd7:  w = "else  ";
      4'd8:  w = "while ";
      4'd9:  w = "for   ";
      4'd10: w = "scanf ";
      4'd11: w = "printf";
      4'd12: w = "return";
      default: w = 48'd0;
    endcase
    kw_byte = w[47 - 8*i -: 8];
  endfunction

  function automatic logic [2:0] kw_len(input logic [3:0] k);
    unique case (k)
      4'd0, 4'd8, 4'd10: kw_len = 3'd5;
      4'd1, 4'd9:        kw_len = 3'd3;
      4'd5, 4'd6:        kw_len = 3'd2;
      4'd11, 4'd12:      kw_len = 3'd6;
      default:           kw_len = 3'd4;
    endcase
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    case (c)
      "+": single_kind = 6'd18;
      "-": single_kind = 6'd19;
      "*": single_kind = 6'd20;
      "/": single_kind = 6'd21;
      ";": single_kind = 6'd29;
      ",": single_kind = 6'd30;
      "(": single_kind = 6'd31;
      ")": single_kind = 6'd32;
      "[": single_kind = 6'd33;
      "]": single_kind = 6'd34;
      "{": single_kind = 6'd35;
      "}": single_kind = 6'd36;
      default: single_kind = K_NONE;
    endcase
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = c >= "0" && c <= "9";
  endfunction
endpackage
`default_nettype wire

### rtl/scs_ram.sv
`default_nettype none
module scs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/small_c_token_scanner_unit.sv
`default_nettype none
// channel | direction | ports
// in      | input     | in_valid, in_stall, in_ch, in_is_end
// out     | output    | out_valid, out_stall, out_token_kind .. out_last
//
// At a token end the buffered text characters are replayed from the text RAM,
// one result item per cycle while the output is not stalled; keywords are
// narrowed as the text is built. A two-character operator is sent as two
// items, the second from P_DBL, and a byte that ends a token or opens a skip
// is held and scanned afresh after the last result. Reset is synchronous on
// rst_n and needs no clearing pass. A stalled output holds its item and the
// input is stalled until the sequencer is free.
module small_c_token_scanner_unit
  import scs_pkg::*;
#(
  parameter int MAX_TEXT = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_ch,
  input  wire logic        in_is_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [5:0]       out_token_kind,
  output logic [19:0]      out_line,
  output logic [15:0]      out_col,
  output logic [7:0]       out_text_char,
  output logic             out_has_char,
  output logic             out_overlong,
  output logic             out_last
);
  localparam int AW = $clog2(MAX_TEXT);
  localparam int LW = $clog2(MAX_TEXT + 1);

  localparam logic [1:0] P_IN   = 2'd0;
  localparam logic [1:0] P_PLAY = 2'd1;
  localparam logic [1:0] P_DBL  = 2'd2;

  typedef struct packed {
    logic [5:0] kind;
    logic [7:0] tc;
    logic       has;
    logic       ovf;
    logic       last;
  } item_t;

  logic [3:0]    mode_r, mode_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic          ovf_r, ovf_nxt;
  logic [7:0]    pop_r, pop_nxt;
  logic [19:0]   line_r, line_nxt;
  logic [15:0]   col_r, col_nxt;
  logic [12:0]   kwm_r, kwm_nxt;   // keyword still matches prefix
  logic [7:0]    first_r, first_nxt;

  logic [1:0]    ph_r, ph_nxt;
  logic [LW-1:0] pidx_r, pidx_nxt;
  logic [LW-1:0] plen_r, plen_nxt;
  logic [5:0]    pkind_r, pkind_nxt;
  logic          povf_r, povf_nxt;
  logic [7:0]    hold_ch_r, hold_ch_nxt;
  logic          hold_r, hold_nxt;  // a byte waits to be scanned afresh

  logic          ov_r, ov_nxt;
  item_t         oi_r, oi_nxt;
  logic [19:0]   oline_r, oline_nxt;
  logic [15:0]   ocol_r, ocol_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  scs_ram #(.WIDTH(8), .DEPTH(MAX_TEXT)) u_text (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic out_free;
  assign out_free = !ov_r || !out_stall;
  assign in_stall = !(ph_r == P_IN && !hold_r && out_free);

  assign out_valid      = ov_r;
  assign out_token_kind = oi_r.kind;
  assign out_line       = oline_r;
  assign out_col        = ocol_r;
  assign out_text_char  = oi_r.tc;
  assign out_has_char   = oi_r.has;
  assign out_overlong   = oi_r.ovf;
  assign out_last       = oi_r.last;

  function automatic logic [5:0] kw_kind(input logic [12:0] m, input logic [LW-1:0] l,
                                         input logic o);
    logic [5:0] k;
    k = K_IDENT;
    for (int i = NKW - 1; i >= 0; i--)
      if (m[i] && !o && l == LW'(kw_len(4'(i)))) k = K_KW0 + 6'(i);
    return k;
  endfunction

  always_comb begin
    logic [7:0]  c;
    logic        go, emit, sc, endp, pre;
    item_t       it;
    logic        col_i, line_i, app, clr, play;
    logic [5:0]  sk;

    mode_nxt = mode_r; len_nxt = len_r; ovf_nxt = ovf_r; pop_nxt = pop_r;
    line_nxt = line_r; col_nxt = col_r; kwm_nxt = kwm_r; first_nxt = first_r;
    ph_nxt = ph_r; pidx_nxt = pidx_r; plen_nxt = plen_r; pkind_nxt = pkind_r;
    povf_nxt = povf_r; hold_ch_nxt = hold_ch_r; hold_nxt = hold_r;
    ov_nxt = ov_r && out_stall; oi_nxt = oi_r; oline_nxt = oline_r; ocol_nxt = ocol_r;
    we = 1'b0; waddr = len_r[AW-1:0]; wdata = 8'd0; raddr = pidx_r[AW-1:0];
    emit = 1'b0; it = '0; col_i = 1'b0; line_i = 1'b0; app = 1'b0; clr = 1'b0;
    play = 1'b0; sc = 1'b0; endp = 1'b0; pre = 1'b0;
    c = hold_r ? hold_ch_r : in_ch;
    sk = single_kind(c);
    go = out_free && ph_r == P_IN && (hold_r || (in_valid && !in_stall));

    unique case (ph_r)
      // replay buffered text one item per cycle while the output is not stalled
      P_PLAY: begin
        if (out_free) begin
          emit = 1'b1;
          it = '{pkind_r, rdata, 1'b1, povf_r, pidx_r + 1'b1 == plen_r};
          pidx_nxt = pidx_r + 1'b1;
          raddr = pidx_nxt[AW-1:0];
          if (pidx_r + 1'b1 == plen_r) ph_nxt = P_IN;
        end else raddr = pidx_r[AW-1:0];
      end
      // second half of a two-character operator
      P_DBL: begin
        if (out_free) begin
          emit = 1'b1; it = '{pkind_r, "=", 1'b1, 1'b0, 1'b1}; ph_nxt = P_IN;
        end
      end
      default: begin
        if (go) begin
          hold_nxt = 1'b0;
          if (!hold_r && in_is_end) begin
            unique case (mode_r)
              M_IDENT, M_NUM: begin
                play = 1'b1;
                pkind_nxt = mode_r == M_IDENT ? kw_kind(kwm_r, len_r, ovf_r) : K_NUM;
              end
              M_STR: begin emit = 1'b1; it = '{K_ERR_ST, 8'd0, 1'b0, 1'b0, 1'b1}; end
              M_CHR1, M_CHR2: begin
                emit = 1'b1; it = '{K_ERR_CH, 8'd0, 1'b0, 1'b0, 1'b1};
              end
              M_OP: begin
                emit = 1'b1;
                if (pop_r == "!") it = '{K_ERR_SY, 8'd0, 1'b0, 1'b0, 1'b1};
                else it = '{pop_r == "<" ? K_LT : pop_r == ">" ? K_GT : K_ASSIGN,
                            pop_r, 1'b1, 1'b0, 1'b1};
              end
              default: ;
            endcase
            endp = 1'b1;
            mode_nxt = M_IDLE; pop_nxt = 8'd0;
          end else begin
            unique case (mode_r)
              M_IDENT, M_NUM: begin
                if (is_digit(c) || (mode_r == M_IDENT && is_alpha(c))) begin
                  app = 1'b1; col_i = 1'b1;
                end else begin
                  play = 1'b1;
                  pkind_nxt = mode_r == M_IDENT ? kw_kind(kwm_r, len_r, ovf_r) : K_NUM;
                  hold_nxt = 1'b1; hold_ch_nxt = c; mode_nxt = M_IDLE;
                end
              end
              M_STR: begin
                if (c == "\"") begin
                  col_i = 1'b1; mode_nxt = M_IDLE; pkind_nxt = K_STRING;
                  if (len_r == '0) begin
                    emit = 1'b1; it = '{K_STRING, 8'd0, 1'b0, ovf_r, 1'b1}; clr = 1'b1;
                  end else play = 1'b1;
                end else if (c == "\n") begin
                  // the error carries the position before the newline is counted
                  emit = 1'b1; it = '{K_ERR_ST, 8'd0, 1'b0, 1'b0, 1'b1}; pre = 1'b1;
                  clr = 1'b1; mode_nxt = M_IDLE; line_i = 1'b1;
                end else begin app = 1'b1; col_i = 1'b1; end
              end
              M_CHR1: begin
                if (is_alpha(c) || is_digit(c) || c == "+" || c == "-" ||
                    c == "*" || c == "/") begin
                  first_nxt = c; col_i = 1'b1; mode_nxt = M_CHR2;
                end else sc = 1'b1;
              end
              M_CHR2: begin
                if (c == "'") begin
                  col_i = 1'b1; emit = 1'b1; it = '{K_CHAR, first_r, 1'b1, 1'b0, 1'b1};
                  mode_nxt = M_IDLE;
                end else sc = 1'b1;
              end
              M_OP: begin
                if (pop_r == "!") begin
                  pop_nxt = 8'd0;
                  if (c == "=") begin
                    col_i = 1'b1; emit = 1'b1; it = '{K_NE, "!", 1'b1, 1'b0, 1'b0};
                    pkind_nxt = K_NE; ph_nxt = P_DBL; mode_nxt = M_IDLE;
                  end else begin
                    emit = 1'b1; it = '{K_ERR_SY, 8'd0, 1'b0, 1'b0, 1'b1};
                    mode_nxt = M_SKIP; hold_nxt = 1'b1; hold_ch_nxt = c;
                  end
                end else if (c == "=") begin
                  col_i = 1'b1; emit = 1'b1;
                  pkind_nxt = pop_r == "<" ? K_LE : pop_r == ">" ? K_GE : K_EQ;
                  it = '{pkind_nxt, pop_r, 1'b1, 1'b0, 1'b0};
                  ph_nxt = P_DBL; pop_nxt = 8'd0; mode_nxt = M_IDLE;
                end else begin
                  emit = 1'b1;
                  it = '{pop_r == "<" ? K_LT : pop_r == ">" ? K_GT : K_ASSIGN,
                         pop_r, 1'b1, 1'b0, 1'b1};
                  pop_nxt = 8'd0; mode_nxt = M_IDLE;
                  hold_nxt = 1'b1; hold_ch_nxt = c;
                end
              end
              M_SKIP: begin
                if (c == ";") begin
                  mode_nxt = M_IDLE; hold_nxt = 1'b1; hold_ch_nxt = c;
                end else if (c == "\n") line_i = 1'b1;
                else col_i = 1'b1;
              end
              default: begin
                if (c == " " || c == "\t" || c == "\r") col_i = 1'b1;
                else if (c == "\n") line_i = 1'b1;
                else if (is_alpha(c) || (c >= "1" && c <= "9")) begin
                  clr = 1'b1; app = 1'b1; col_i = 1'b1;
                  mode_nxt = is_alpha(c) ? M_IDENT : M_NUM;
                end else if (c == "0") begin
                  col_i = 1'b1; emit = 1'b1; it = '{K_ZERO, "0", 1'b1, 1'b0, 1'b1};
                end else if (c == "\"") begin
                  col_i = 1'b1; clr = 1'b1; mode_nxt = M_STR;
                end else if (c == "'") begin
                  col_i = 1'b1; mode_nxt = M_CHR1;
                end else if (sk != K_NONE) begin
                  col_i = 1'b1; emit = 1'b1; it = '{sk, c, 1'b1, 1'b0, 1'b1};
                end else if (c == "<" || c == ">" || c == "=" || c == "!") begin
                  col_i = 1'b1; pop_nxt = c; mode_nxt = M_OP;
                end else begin
                  col_i = 1'b1; emit = 1'b1; it = '{K_ERR_SY, 8'd0, 1'b0, 1'b0, 1'b1};
                  mode_nxt = M_SKIP;
                end
              end
            endcase
            // bad char literal: error now, byte goes to the skip scan
            if (sc) begin
              emit = 1'b1; it = '{K_ERR_CH, 8'd0, 1'b0, 1'b0, 1'b1};
              mode_nxt = M_SKIP; hold_nxt = 1'b1; hold_ch_nxt = c;
            end
          end

          // column and line counters advance before the token is shown
          if (col_i && col_r != COL_MAX) col_nxt = col_r + 1'b1;
          if (line_i) begin
            if (line_r != LINE_MAX) line_nxt = line_r + 1'b1;
            col_nxt = 16'd0;
          end

          // start the replay: the first RAM word is read this cycle
          if (play) begin
            ph_nxt = P_PLAY; pidx_nxt = '0; plen_nxt = len_r; povf_nxt = ovf_r;
            raddr = '0;
            clr = 1'b1;
            if (len_r == '0) begin
              ph_nxt = P_IN; emit = 1'b1; it = '{pkind_nxt, 8'd0, 1'b0, ovf_r, 1'b1};
            end
          end
          if (endp) clr = 1'b1;

          if (clr) begin len_nxt = '0; ovf_nxt = 1'b0; kwm_nxt = '1; end
          // append to the text RAM and narrow the keyword candidates
          if (app) begin
            if ((clr ? '0 : len_r) < LW'(MAX_TEXT)) begin
              we = 1'b1; waddr = clr ? '0 : len_r[AW-1:0]; wdata = c;
              len_nxt = (clr ? '0 : len_r) + 1'b1;
              for (int i = 0; i < NKW; i++)
                if ((clr ? '0 : len_r) >= LW'(6) ||
                    kw_byte(4'(i), 3'((clr ? '0 : len_r))) != c)
                  kwm_nxt[i] = 1'b0;
            end else ovf_nxt = 1'b1;
          end
        end
      end
    endcase

    if (emit) begin
      ov_nxt = 1'b1; oi_nxt = it; oline_nxt = line_nxt; ocol_nxt = col_nxt;
      if (ph_r != P_IN || pre) begin oline_nxt = line_r; ocol_nxt = col_r; end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; len_r <= '0; ovf_r <= 1'b0; pop_r <= 8'd0;
      line_r <= 20'd1; col_r <= 16'd0; kwm_r <= '1; ph_r <= P_IN;
      hold_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt; len_r <= len_nxt; ovf_r <= ovf_nxt; pop_r <= pop_nxt;
      line_r <= line_nxt; col_r <= col_nxt; kwm_r <= kwm_nxt; ph_r <= ph_nxt;
      hold_r <= hold_nxt; ov_r <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    first_r <= first_nxt; pidx_r <= pidx_nxt; plen_r <= plen_nxt;
    pkind_r <= pkind_nxt; povf_r <= povf_nxt; hold_ch_r <= hold_ch_nxt;
    oi_r <= oi_nxt; oline_r <= oline_nxt; ocol_r <= ocol_nxt;
  end

`ifndef ASSERT_OFF
  a_len: assert property (@(posedge clk) disable iff (!rst_n) len_r <= LW'(MAX_TEXT))
    else $error("text length beyond buffer");
  a_play_stall: assert property (@(posedge clk) disable iff (!rst_n)
    ph_r != P_IN |-> in_stall) else $error("input taken during replay");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid && $stable(oi_r))
    else $error("stalled item changed");
`endif
endmodule
`default_nettype wire
